/* rtl/core/acpe_pkg.sv */
// Shared types and constants of the air-conditioner remote frame encoder.
package acpe_pkg;

	localparam int FRAME_LEN    = 9;
	localparam int SYMBOL_COUNT = 148;
	localparam int POS_W        = 8;
	localparam int DUR_W        = 16;
	localparam int CFG_IDX_W    = 3;

	// commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP          = 3'd5;

	// register reset values
	localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd4400;
	localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4300;
	localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd580;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1600;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd490;
	localparam logic [DUR_W-1:0] RST_GAP          = 16'd7400;

	// fixed frame bytes
	localparam logic [7:0] FB0 = 8'hF2;
	localparam logic [7:0] FB1 = 8'h0D;
	localparam logic [7:0] FB2 = 8'h03;
	localparam logic [7:0] FB3 = 8'hFC;
	localparam logic [7:0] FB4 = 8'h01;
	localparam logic [7:0] FB7 = 8'h00;

	localparam logic [7:0] TEMP_MIN  = 8'd17;
	localparam logic [7:0] TEMP_MAX  = 8'd30;
	localparam logic [2:0] MODE_MAX  = 3'd4;
	localparam logic [2:0] MODE_AUTO = 3'd0;
	localparam logic [2:0] MODE_OFF  = 3'd7;
	localparam logic [2:0] SWING_ON_CODE  = 3'd1;
	localparam logic [2:0] SWING_OFF_CODE = 3'd2;

	typedef struct packed {
		logic [DUR_W-1:0] header_mark;
		logic [DUR_W-1:0] header_space;
		logic [DUR_W-1:0] bit_mark;
		logic [DUR_W-1:0] one_space;
		logic [DUR_W-1:0] zero_space;
		logic [DUR_W-1:0] gap;
	} timing_t;

	typedef struct packed {
		logic [7:0] b5;
		logic [7:0] b6;
		logic [7:0] cks;
	} frame_var_t;

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic             is_mark;
		logic             last;
		logic             active;
	} result_t;

endpackage

/* rtl/core/acpe_frame.sv */
// Builds the variable frame bytes and the checksum from the settings.
module acpe_frame (
	input  logic [7:0]              temperature_c,
	input  logic [2:0]              ac_mode,
	input  logic [1:0]              fan_speed,
	input  logic                    swing_on,
	input  logic                    power_on,
	output acpe_pkg::frame_var_t    frame
);

	logic [7:0] temp_clamped;
	logic [7:0] temp_ofs;
	logic [2:0] mode_code;
	logic [2:0] swing_code;

	always_comb begin
		if (temperature_c < acpe_pkg::TEMP_MIN) begin
			temp_clamped = acpe_pkg::TEMP_MIN;
		end else if (temperature_c > acpe_pkg::TEMP_MAX) begin
			temp_clamped = acpe_pkg::TEMP_MAX;
		end else begin
			temp_clamped = temperature_c;
		end
		temp_ofs = temp_clamped - acpe_pkg::TEMP_MIN;

		if (!power_on) begin
			mode_code = acpe_pkg::MODE_OFF;
		end else if (ac_mode > acpe_pkg::MODE_MAX) begin
			mode_code = acpe_pkg::MODE_AUTO;
		end else begin
			mode_code = ac_mode;
		end

		swing_code = swing_on ? acpe_pkg::SWING_ON_CODE : acpe_pkg::SWING_OFF_CODE;

		frame.b5  = {temp_ofs[3:0], 1'b0, swing_code};
		// fan code is twice the speed, placed in bits 7..5
		frame.b6  = {fan_speed, 1'b0, 2'b00, mode_code};
		frame.cks = acpe_pkg::FB0 ^ acpe_pkg::FB1 ^ acpe_pkg::FB2 ^ acpe_pkg::FB3
		          ^ acpe_pkg::FB4 ^ frame.b5 ^ frame.b6 ^ acpe_pkg::FB7;
	end

endmodule

/* rtl/core/acpe_seq.sv */
// Symbol sequencer: frame store, position counter and duration select.
module acpe_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  command,
	input  acpe_pkg::frame_var_t  frame_in,
	input  acpe_pkg::timing_t     timing,
	output acpe_pkg::result_t     result
);

	localparam logic [acpe_pkg::POS_W-1:0] LAST_POS =
		acpe_pkg::POS_W'(acpe_pkg::SYMBOL_COUNT - 1);
	localparam logic [acpe_pkg::POS_W-1:0] FOOTER_POS =
		acpe_pkg::POS_W'(acpe_pkg::SYMBOL_COUNT - 2);
	localparam logic [acpe_pkg::POS_W-1:0] HDR_SPACE_POS = 8'd1;
	localparam logic [acpe_pkg::POS_W-1:0] FIRST_BIT_POS = 8'd2;

	logic [acpe_pkg::POS_W-1:0] pos_q;
	logic                       sending_q;
	acpe_pkg::frame_var_t       frame_q;

	logic [acpe_pkg::POS_W-1:0] p;
	logic [acpe_pkg::POS_W-1:0] q;
	logic [7:0]                 cur_byte;
	logic                       bit_val;
	logic                       start;
	logic                       emit;

	assign start = (command == acpe_pkg::CMD_START);
	assign emit  = start || sending_q;
	// a start always emits the header mark, which needs no frame byte
	assign p     = start ? '0 : pos_q;
	assign q     = p - FIRST_BIT_POS;

	always_comb begin
		case (q[7:4])
			4'd0:    cur_byte = acpe_pkg::FB0;
			4'd1:    cur_byte = acpe_pkg::FB1;
			4'd2:    cur_byte = acpe_pkg::FB2;
			4'd3:    cur_byte = acpe_pkg::FB3;
			4'd4:    cur_byte = acpe_pkg::FB4;
			4'd5:    cur_byte = frame_q.b5;
			4'd6:    cur_byte = frame_q.b6;
			4'd7:    cur_byte = acpe_pkg::FB7;
			default: cur_byte = frame_q.cks;
		endcase
		// MSB first: bit 7 - q[3:1]
		bit_val = cur_byte[~q[3:1]];
	end

	always_comb begin
		result = '0;
		if (emit) begin
			result.active = 1'b1;
			if (p == '0) begin
				result.duration = timing.header_mark;
				result.is_mark  = 1'b1;
			end else if (p == HDR_SPACE_POS) begin
				result.duration = timing.header_space;
			end else if (p < FOOTER_POS) begin
				if (!q[0]) begin
					result.duration = timing.bit_mark;
					result.is_mark  = 1'b1;
				end else begin
					result.duration = bit_val ? timing.one_space : timing.zero_space;
				end
			end else if (p == FOOTER_POS) begin
				result.duration = timing.bit_mark;
				result.is_mark  = 1'b1;
			end else begin
				result.duration = timing.gap;
				result.last     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sending_q <= 1'b0;
		end else if (accept && emit) begin
			if (p >= LAST_POS) begin
				pos_q     <= '0;
				sending_q <= 1'b0;
			end else begin
				pos_q     <= p + 8'd1;
				sending_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && start) begin
			frame_q <= frame_in;
		end
	end

endmodule

/* rtl/core/ac_ir_frame_pulse_encoder_unit.sv */
// Top level of the air-conditioner remote frame encoder.
//
// Request channel (req_valid / req_stall) carries a command with settings.
// A start command (command 0) latches the settings into a nine-byte frame and
// returns the header mark; each next command (command 1) returns the
// following duration, 148 in a frame, the final gap flagged with last.
// A next command with no frame running returns an inactive item.
// Response channel (rsp_valid / rsp_stall) carries one item per request.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one item per cycle unless the receiver stalls; the sequencer and duration select finish
// in the cycle of acceptance and the response register holds the result.
// req_stall rises only while a response is waiting and the receiver stalls;
// a request is still taken in the cycle the waiting response leaves.
// Timing registers are written through cfg_we / cfg_index / cfg_data,
// indexes above 5 are ignored.
// Reset clears the position counter, the running flag and the response
// valid, and loads the timing registers with their default durations.
module ac_ir_frame_pulse_encoder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [acpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [acpe_pkg::DUR_W-1:0]          cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                command,
	input  logic [7:0]                          temperature_c,
	input  logic [2:0]                          ac_mode,
	input  logic [1:0]                          fan_speed,
	input  logic                                swing_on,
	input  logic                                power_on,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [acpe_pkg::DUR_W-1:0]          duration_us,
	output logic                                is_mark,
	output logic                                last,
	output logic                                active
);

	acpe_pkg::timing_t    timing_q;
	acpe_pkg::frame_var_t frame;
	acpe_pkg::result_t    result;
	acpe_pkg::result_t    rsp_q;
	logic                 rsp_valid_q;
	logic                 accept;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.header_mark  <= acpe_pkg::RST_HEADER_MARK;
			timing_q.header_space <= acpe_pkg::RST_HEADER_SPACE;
			timing_q.bit_mark     <= acpe_pkg::RST_BIT_MARK;
			timing_q.one_space    <= acpe_pkg::RST_ONE_SPACE;
			timing_q.zero_space   <= acpe_pkg::RST_ZERO_SPACE;
			timing_q.gap          <= acpe_pkg::RST_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				acpe_pkg::REG_HEADER_MARK:  timing_q.header_mark  <= cfg_data;
				acpe_pkg::REG_HEADER_SPACE: timing_q.header_space <= cfg_data;
				acpe_pkg::REG_BIT_MARK:     timing_q.bit_mark     <= cfg_data;
				acpe_pkg::REG_ONE_SPACE:    timing_q.one_space    <= cfg_data;
				acpe_pkg::REG_ZERO_SPACE:   timing_q.zero_space   <= cfg_data;
				acpe_pkg::REG_GAP:          timing_q.gap          <= cfg_data;
				default: ;
			endcase
		end
	end

	acpe_frame u_frame (
		.temperature_c (temperature_c),
		.ac_mode       (ac_mode),
		.fan_speed     (fan_speed),
		.swing_on      (swing_on),
		.power_on      (power_on),
		.frame         (frame)
	);

	acpe_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.frame_in (frame),
		.timing   (timing_q),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign duration_us = rsp_q.duration;
	assign is_mark     = rsp_q.is_mark;
	assign last        = rsp_q.last;
	assign active      = rsp_q.active;

endmodule

/* rtl/core/acpe_checker.sv */
// Port-level checks of the frame encoder, bound to the top level.
module acpe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_stall,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input logic [acpe_pkg::DUR_W-1:0]     duration_us,
	input logic                           is_mark,
	input logic                           last,
	input logic                           active
);

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(duration_us)
			&& $stable(is_mark) && $stable(last) && $stable(active))
		else $error("response changed while stalled");

	// every accepted request yields a response in the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request gave no response");

	// an inactive item carries nothing
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !active |-> duration_us == '0 && !is_mark && !last)
		else $error("inactive item with payload");

	// the frame ends on a silence of a running frame
	a_last_space: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && last |-> active && !is_mark)
		else $error("last flag on a mark or inactive item");

endmodule

bind ac_ir_frame_pulse_encoder_unit acpe_checker u_acpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.duration_us (duration_us),
	.is_mark     (is_mark),
	.last        (last),
	.active      (active)
);
